// ===== rtl/tsbw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbw_pkg
// types and constants shared by the texture sampler and its texel memory
// ----------------------------------------------------------------------------
package tsbw_pkg;

  localparam int MaxTexelsDefault = 65536;
  localparam int TexelWidth       = 24;

  // request codes
  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;

  // filter codes
  localparam logic FilterNearest  = 1'b0;
  localparam logic FilterBilinear = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEX_WIDTH   = 3'd0,
    CFG_TEX_HEIGHT  = 3'd1,
    CFG_U_SCALE     = 3'd2,
    CFG_V_SCALE     = 3'd3,
    CFG_FILTER_MODE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               op;
    logic        [15:0] texel_index;
    logic        [7:0]  texel_red;
    logic        [7:0]  texel_green;
    logic        [7:0]  texel_blue;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

endpackage

// ===== rtl/tsbw_ram.sv =====
// ----------------------------------------------------------------------------
// tsbw_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tsbw_ram #(
  parameter int Width = tsbw_pkg::TexelWidth,
  parameter int Depth = tsbw_pkg::MaxTexelsDefault
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/texture_sample_bilinear_wrap.sv =====
// ----------------------------------------------------------------------------
// texture_sample_bilinear_wrap
// rgb888 texture store with wrapped nearest and bilinear sampling
// ----------------------------------------------------------------------------
// Requests enter a nine-stage coordinate pipeline (two multiplies, a magnitude
// step, five stages of 7-bit modulo reduction and a floor correction) and then
// a fetch stage on the single read port of the texel memory. A texel write or a
// nearest sample takes one texel access in the fetch stage and a bilinear
// sample four (one texel read per cycle), so writes and nearest samples flow at
// one request per cycle while busy stays low. busy rises only while the fetch
// stage is still working on an earlier request. Texel reads return from the
// registered read port and are accumulated; done rises after the last read of a
// sample and res holds the result in that cycle; results cannot be held off, so
// capture them on done. Writes produce no result. Texels that were never
// written read back as garbage.
module texture_sample_bilinear_wrap #(
  parameter int MAX_TEXELS = tsbw_pkg::MaxTexelsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsbw_pkg::req_t    req,
  output logic              done,
  output tsbw_pkg::res_t    res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AW     = $clog2(MAX_TEXELS);
  localparam int NStage = 9;
  localparam logic [22:0] Cap = 23'(MAX_TEXELS);

  typedef struct packed {
    logic signed [60:0] prod;
    logic               neg;
    logic [34:0]        mag;
    logic [10:0]        rem;
    logic [7:0]         frac;
  } coord_t;

  typedef struct packed {
    logic         op;
    logic [15:0]  idx;
    logic [23:0]  texel;
    coord_t [1:0] crd;
  } stage_t;

  // configuration
  logic [10:0] tex_width;
  logic [10:0] tex_height;
  logic [15:0] u_scale;
  logic [15:0] v_scale;
  logic        filter_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= 11'd256;
      tex_height  <= 11'd256;
      u_scale     <= 16'd256;
      v_scale     <= 16'd256;
      filter_mode <= tsbw_pkg::FilterBilinear;
    end else if (cfg_valid) begin
      unique case (tsbw_pkg::cfg_reg_t'(cfg_index))
        tsbw_pkg::CFG_TEX_WIDTH:   tex_width   <= cfg_data[10:0];
        tsbw_pkg::CFG_TEX_HEIGHT:  tex_height  <= cfg_data[10:0];
        tsbw_pkg::CFG_U_SCALE:     u_scale     <= cfg_data;
        tsbw_pkg::CFG_V_SCALE:     v_scale     <= cfg_data;
        tsbw_pkg::CFG_FILTER_MODE: filter_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [10:0] sz  [2];
  logic [15:0] scl [2];

  always_comb begin
    sz[0]  = (tex_width  == 11'd0) ? 11'd1 : tex_width;
    sz[1]  = (tex_height == 11'd0) ? 11'd1 : tex_height;
    scl[0] = u_scale;
    scl[1] = v_scale;
  end

  // seven restoring remainder steps, msb first
  function automatic logic [10:0] mod_step(input logic [10:0] r_in, input logic [6:0] b,
                                           input logic [10:0] s);
    logic [11:0] t;
    logic [10:0] r;
    r = r_in;
    for (int k = 6; k >= 0; k--) begin
      t = {r, b[k]};
      if (t >= {1'b0, s}) begin
        t = t - {1'b0, s};
      end
      r = t[10:0];
    end
    return r;
  endfunction

  // coordinate pipeline
  stage_t              st  [NStage];
  stage_t              nxt [NStage];
  logic [NStage-1:0]   st_valid;
  logic                en;

  logic signed [43:0]  m1  [2];
  logic signed [60:0]  p2  [2];
  logic signed [36:0]  ipv [2];

  always_comb begin
    nxt[0].op    = req.op;
    nxt[0].idx   = req.texel_index;
    nxt[0].texel = {req.texel_red, req.texel_green, req.texel_blue};
    m1[0] = req.coord_u * $signed({1'b0, sz[0]});
    m1[1] = req.coord_v * $signed({1'b0, sz[1]});
    for (int j = 0; j < 2; j++) begin
      nxt[0].crd[j]      = '0;
      nxt[0].crd[j].prod = 61'(m1[j]);
    end
    for (int i = 1; i < NStage; i++) begin
      nxt[i] = st[i-1];
    end
    for (int j = 0; j < 2; j++) begin
      p2[j] = $signed(st[0].crd[j].prod[43:0]) * $signed({1'b0, scl[j]});
      nxt[1].crd[j].prod = p2[j];
      // floor of the q.24 product, then its magnitude
      ipv[j] = st[1].crd[j].prod[60:24];
      nxt[2].crd[j].neg  = ipv[j][36];
      nxt[2].crd[j].mag  = ipv[j][36] ? 35'(-ipv[j]) : 35'(ipv[j]);
      nxt[2].crd[j].frac = st[1].crd[j].prod[23:16];
      nxt[2].crd[j].rem  = '0;
      for (int c = 0; c < 5; c++) begin
        nxt[3+c].crd[j].rem = mod_step(st[2+c].crd[j].rem,
                                       st[2+c].crd[j].mag[34-7*c -: 7], sz[j]);
      end
      // negative positions wrap from the top
      if (st[7].crd[j].neg && st[7].crd[j].rem != 11'd0) begin
        nxt[8].crd[j].rem = sz[j] - st[7].crd[j].rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (en) begin
      st_valid <= {st_valid[NStage-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NStage; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  // fetch stage
  logic        bvalid;
  logic        bop;
  logic [15:0] bidx;
  logic [23:0] btexel;
  logic [10:0] bu;
  logic [10:0] bv;
  logic [7:0]  bfu;
  logic [7:0]  bfv;
  logic [1:0]  k;
  logic        last_issue;
  logic        take;

  assign last_issue = bvalid && (bop == tsbw_pkg::OpWrite ||
                                 filter_mode == tsbw_pkg::FilterNearest || k == 2'd3);
  assign take = st_valid[NStage-1] && (!bvalid || last_issue);
  assign en   = !(st_valid[NStage-1] && bvalid && !last_issue);
  assign busy = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      k      <= '0;
    end else if (take) begin
      bvalid <= 1'b1;
      k      <= '0;
    end else if (last_issue) begin
      bvalid <= 1'b0;
    end else if (bvalid) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bop    <= st[NStage-1].op;
      bidx   <= st[NStage-1].idx;
      btexel <= st[NStage-1].texel;
      bu     <= st[NStage-1].crd[0].rem;
      bv     <= st[NStage-1].crd[1].rem;
      bfu    <= st[NStage-1].crd[0].frac;
      bfv    <= st[NStage-1].crd[1].frac;
    end
  end

  logic [11:0] u_inc;
  logic [11:0] v_inc;
  logic [10:0] col;
  logic [10:0] row;
  logic [21:0] addr;
  logic        in_range;
  logic [8:0]  wa;
  logic [8:0]  wb;
  logic [16:0] wt;

  always_comb begin
    u_inc = {1'b0, bu} + 12'd1;
    v_inc = {1'b0, bv} + 12'd1;
    col   = (k[0] && u_inc != {1'b0, sz[0]}) ? u_inc[10:0] : (k[0] ? 11'd0 : bu);
    row   = (k[1] && v_inc != {1'b0, sz[1]}) ? v_inc[10:0] : (k[1] ? 11'd0 : bv);
    if (bop == tsbw_pkg::OpWrite) begin
      addr = {6'd0, bidx};
    end else begin
      addr = 22'(row) * 22'(sz[0]) + 22'(col);
    end
    in_range = {1'b0, addr} < Cap;
    wa = k[0] ? {1'b0, bfu} : 9'd256 - {1'b0, bfu};
    wb = k[1] ? {1'b0, bfv} : 9'd256 - {1'b0, bfv};
    if (filter_mode == tsbw_pkg::FilterNearest) begin
      wt = 17'h10000;
    end else begin
      wt = 17'(wa) * 17'(wb);
    end
  end

  logic [23:0] rdata;

  tsbw_ram #(
    .Width(tsbw_pkg::TexelWidth),
    .Depth(MAX_TEXELS)
  ) u_ram (
    .clk  (clk),
    .we   (bvalid && bop == tsbw_pkg::OpWrite && in_range),
    .waddr(addr[AW-1:0]),
    .wdata(btexel),
    .raddr(addr[AW-1:0]),
    .rdata(rdata)
  );

  // read return and accumulate
  logic        rvalid;
  logic        rfirst;
  logic        rlast;
  logic        rzero;
  logic [16:0] rwt;
  logic [23:0] tex;
  logic [24:0] acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      rvalid <= bvalid && bop == tsbw_pkg::OpSample;
      done   <= rvalid && rlast;
    end
  end

  always_ff @(posedge clk) begin
    rfirst <= k == 2'd0;
    rlast  <= last_issue;
    rzero  <= !in_range;
    rwt    <= wt;
  end

  assign tex = rzero ? 24'd0 : rdata;

  always_ff @(posedge clk) begin
    if (rvalid) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= (rfirst ? 25'd0 : acc[c]) + 25'(tex[16-8*c +: 8]) * 25'(rwt);
      end
    end
  end

  logic [24:0] rnd [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = acc[c] + 25'd32768;
    end
    res.red   = rnd[0][23:16];
    res.green = rnd[1][23:16];
    res.blue  = rnd[2][23:16];
  end

endmodule
